>>> src/line_rect_raster_engine_defines.svh
// assertion macros for the line and rectangle raster engine
`ifndef LINE_RECT_RASTER_ENGINE_DEFINES_SVH
`define LINE_RECT_RASTER_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LRRE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lrre assertion failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LRRE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lrre assertion failed");

`endif

>>> src/lrre_pkg.sv
// shared types and constants of the line and rectangle raster engine
`timescale 1ns / 1ps
`default_nettype none

package lrre_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam int SCREEN_W_LO = 320;
    localparam int SCREEN_H_LO = 240;
    localparam int SCREEN_W_HI = 640;
    localparam int SCREEN_H_HI = 480;

    localparam logic [7:0] MASK_565_RB = 8'hF8;
    localparam logic [7:0] MASK_565_G  = 8'hFC;
    localparam logic [7:0] MASK_332_RG = 8'hE0;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_RECT  = 2'd2,
        CMD_STEP  = 2'd3
    } t_cmd;

    localparam logic [2:0] MODE_640   = 3'd2;
    localparam logic [2:0] MODE_DBL8  = 3'd3;
    localparam logic [2:0] MODE_DBL16 = 3'd4;
    localparam logic [2:0] MODE_RESET = 3'd1;

    localparam logic [2:0] CFG_DISPLAY_MODE = 3'd0;
    localparam logic [2:0] CFG_DRAW_BUFFER  = 3'd1;
    localparam logic [2:0] CFG_COLOUR_RED   = 3'd2;
    localparam logic [2:0] CFG_COLOUR_GREEN = 3'd3;
    localparam logic [2:0] CFG_COLOUR_BLUE  = 3'd4;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] xa;
        logic signed [15:0] ya;
        logic signed [15:0] xb;
        logic signed [15:0] yb;
    } t_in_item;

    typedef struct packed {
        logic               write_valid;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               buffer_select;
        logic [18:0]        pixel_index;
        logic [15:0]        pixel_value;
        logic               shape_done;
    } t_out_item;

    typedef struct packed {
        logic [2:0] display_mode;
        logic       draw_buffer;
        logic [7:0] colour_red;
        logic [7:0] colour_green;
        logic [7:0] colour_blue;
    } t_cfg;

    // position handed from the shape walker to the pixel formatter
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               done;
        logic               blank;
    } t_pos;

endpackage

`default_nettype wire

>>> src/lrre_shape_core.sv
// shape walker: pixel, bresenham line and rectangle position state
`timescale 1ns / 1ps
`default_nettype none

module lrre_shape_core #(
    parameter int COORD_BITS = lrre_pkg::COORD_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire lrre_pkg::t_in_item i_item,
    input  wire lrre_pkg::t_cfg     i_cfg,
    output lrre_pkg::t_pos          o_pos
);
    import lrre_pkg::*;

    localparam int C = COORD_BITS;
    localparam int W = COORD_BITS + 3;

    typedef enum logic [1:0] {
        KIND_IDLE = 2'd0,
        KIND_LINE = 2'd1,
        KIND_RECT = 2'd2
    } t_kind;

    t_kind                  r_kind,  n_kind;
    logic signed [C-1:0]    r_cur_x, n_cur_x;
    logic signed [C-1:0]    r_cur_y, n_cur_y;
    logic signed [C:0]      r_end_x, n_end_x;
    logic signed [C:0]      r_end_y, n_end_y;
    logic signed [C+1:0]    r_err,   n_err;
    logic signed [C:0]      r_dx,    n_dx;
    logic signed [C:0]      r_dy,    n_dy;
    logic                   r_sxn,   n_sxn;
    logic                   r_syn,   n_syn;
    logic signed [C-1:0]    r_left,  n_left;

    logic signed [C-1:0] xa_c, ya_c, xb_c, yb_c;
    logic signed [W-1:0] xa_w, ya_w, xb_w, yb_w;
    logic signed [W-1:0] scr_w, scr_h;
    logic                use_start;

    // line source and step
    logic signed [W-1:0] ddx, ddy;
    logic signed [W-1:0] ls_cx, ls_cy, ls_ex, ls_ey, ls_dx, ls_dy, ls_err;
    logic                ls_sxn, ls_syn;
    logic signed [W-1:0] e2, l_nerr, l_nx, l_ny;
    logic                l_c1, l_c2, l_done;

    // rectangle source and step
    logic signed [W-1:0] sum_x, sum_y, st_ex, st_ey;
    logic                rect_empty;
    logic signed [W-1:0] rs_cx, rs_cy, rs_ex, rs_ey, rs_left;
    logic signed [W-1:0] r_nx, r_ny1, r_ncx, r_ncy;
    logic                r_wrap, r_done;

    logic signed [W-1:0] p_x, p_y;
    logic                p_done, p_blank;

    assign xa_c = i_item.xa[C-1:0];
    assign ya_c = i_item.ya[C-1:0];
    assign xb_c = i_item.xb[C-1:0];
    assign yb_c = i_item.yb[C-1:0];
    assign xa_w = W'(xa_c);
    assign ya_w = W'(ya_c);
    assign xb_w = W'(xb_c);
    assign yb_w = W'(yb_c);

    assign scr_w = (i_cfg.display_mode == MODE_640) ? W'(SCREEN_W_HI) : W'(SCREEN_W_LO);
    assign scr_h = (i_cfg.display_mode == MODE_640) ? W'(SCREEN_H_HI) : W'(SCREEN_H_LO);

    assign use_start = (i_item.cmd != CMD_STEP);

    always_comb begin
        ddx = xb_w - xa_w;
        ddy = yb_w - ya_w;
        if (use_start) begin
            ls_cx  = xa_w;
            ls_cy  = ya_w;
            ls_ex  = xb_w;
            ls_ey  = yb_w;
            ls_dx  = (ddx < 0) ? -ddx : ddx;
            ls_dy  = (ddy < 0) ? -ddy : ddy;
            ls_sxn = !(xa_w < xb_w);
            ls_syn = !(ya_w < yb_w);
            ls_err = ls_dx - ls_dy;
        end else begin
            ls_cx  = W'(r_cur_x);
            ls_cy  = W'(r_cur_y);
            ls_ex  = W'(r_end_x);
            ls_ey  = W'(r_end_y);
            ls_dx  = W'(r_dx);
            ls_dy  = W'(r_dy);
            ls_sxn = r_sxn;
            ls_syn = r_syn;
            ls_err = W'(r_err);
        end
        l_done = (ls_cx == ls_ex) && (ls_cy == ls_ey);
        e2     = ls_err <<< 1;
        l_c1   = (e2 >= -ls_dy);
        l_c2   = (e2 <= ls_dx);
        l_nerr = ls_err - (l_c1 ? ls_dy : W'(0)) + (l_c2 ? ls_dx : W'(0));
        l_nx   = l_c1 ? (ls_sxn ? ls_cx - W'(1) : ls_cx + W'(1)) : ls_cx;
        l_ny   = l_c2 ? (ls_syn ? ls_cy - W'(1) : ls_cy + W'(1)) : ls_cy;
    end

    always_comb begin
        sum_x      = xa_w + xb_w;
        sum_y      = ya_w + yb_w;
        st_ex      = (sum_x > scr_w) ? scr_w : sum_x;
        st_ey      = (sum_y > scr_h) ? scr_h : sum_y;
        rect_empty = (xa_w >= st_ex) || (ya_w >= st_ey);
        if (use_start) begin
            rs_cx   = xa_w;
            rs_cy   = ya_w;
            rs_ex   = st_ex;
            rs_ey   = st_ey;
            rs_left = xa_w;
        end else begin
            rs_cx   = W'(r_cur_x);
            rs_cy   = W'(r_cur_y);
            rs_ex   = W'(r_end_x);
            rs_ey   = W'(r_end_y);
            rs_left = W'(r_left);
        end
        r_nx   = rs_cx + W'(1);
        r_ny1  = rs_cy + W'(1);
        r_wrap = (r_nx >= rs_ex);
        r_done = r_wrap && (r_ny1 >= rs_ey);
        r_ncx  = r_wrap ? rs_left : r_nx;
        r_ncy  = r_wrap ? r_ny1 : rs_cy;
    end

    always_comb begin
        n_kind  = r_kind;
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_end_x = r_end_x;
        n_end_y = r_end_y;
        n_err   = r_err;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_sxn   = r_sxn;
        n_syn   = r_syn;
        n_left  = r_left;
        p_x     = xa_w;
        p_y     = ya_w;
        p_done  = 1'b1;
        p_blank = 1'b0;

        // state for a line position
        if ((i_item.cmd == CMD_LINE) || ((i_item.cmd == CMD_STEP) && (r_kind == KIND_LINE))) begin
            n_cur_x = C'(l_nx);
            n_cur_y = C'(l_ny);
            n_end_x = (C+1)'(ls_ex);
            n_end_y = (C+1)'(ls_ey);
            n_dx    = (C+1)'(ls_dx);
            n_dy    = (C+1)'(ls_dy);
            n_sxn   = ls_sxn;
            n_syn   = ls_syn;
            n_err   = (C+2)'(l_nerr);
            n_kind  = l_done ? KIND_IDLE : KIND_LINE;
        end

        unique case (i_item.cmd)
            CMD_PIXEL: begin
                p_x    = xa_w;
                p_y    = ya_w;
                p_done = 1'b1;
            end
            CMD_LINE: begin
                p_x    = ls_cx;
                p_y    = ls_cy;
                p_done = l_done;
            end
            CMD_RECT: begin
                if (rect_empty) begin
                    p_x     = xa_w;
                    p_y     = ya_w;
                    p_done  = 1'b1;
                    p_blank = 1'b1;
                    n_kind  = KIND_IDLE;
                end else begin
                    p_x     = rs_cx;
                    p_y     = rs_cy;
                    p_done  = r_done;
                    n_cur_x = C'(r_ncx);
                    n_cur_y = C'(r_ncy);
                    n_end_x = (C+1)'(rs_ex);
                    n_end_y = (C+1)'(rs_ey);
                    n_left  = C'(rs_left);
                    n_kind  = r_done ? KIND_IDLE : KIND_RECT;
                end
            end
            CMD_STEP: begin
                unique case (r_kind)
                    KIND_LINE: begin
                        p_x    = ls_cx;
                        p_y    = ls_cy;
                        p_done = l_done;
                    end
                    KIND_RECT: begin
                        p_x     = rs_cx;
                        p_y     = rs_cy;
                        p_done  = r_done;
                        n_cur_x = C'(r_ncx);
                        n_cur_y = C'(r_ncy);
                        n_kind  = r_done ? KIND_IDLE : KIND_RECT;
                    end
                    default: begin
                        p_x     = W'(0);
                        p_y     = W'(0);
                        p_done  = 1'b1;
                        p_blank = 1'b1;
                        n_kind  = KIND_IDLE;
                    end
                endcase
            end
        endcase
    end

    assign o_pos.x     = 16'(p_x);
    assign o_pos.y     = 16'(p_y);
    assign o_pos.done  = p_done;
    assign o_pos.blank = p_blank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_IDLE;
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_end_x <= '0;
            r_end_y <= '0;
            r_err   <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_sxn   <= 1'b0;
            r_syn   <= 1'b0;
            r_left  <= '0;
        end else if (i_fire) begin
            r_kind  <= n_kind;
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_end_x <= n_end_x;
            r_end_y <= n_end_y;
            r_err   <= n_err;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_sxn   <= n_sxn;
            r_syn   <= n_syn;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

>>> src/lrre_pixel_fmt.sv
// pixel formatter: clipping, framebuffer index, buffer and colour packing
`timescale 1ns / 1ps
`default_nettype none

module lrre_pixel_fmt (
    input  wire lrre_pkg::t_cfg i_cfg,
    input  wire lrre_pkg::t_pos i_pos,
    output lrre_pkg::t_out_item o_item
);
    import lrre_pkg::*;

    logic               wide;
    logic signed [15:0] scr_w, scr_h;
    logic               on_screen;
    logic [18:0]        row_w;
    logic [18:0]        index;
    logic [15:0]        colour;
    logic               dbl;

    assign wide      = (i_cfg.display_mode == MODE_640);
    assign scr_w     = wide ? 16'(SCREEN_W_HI) : 16'(SCREEN_W_LO);
    assign scr_h     = wide ? 16'(SCREEN_H_HI) : 16'(SCREEN_H_LO);
    assign on_screen = !i_pos.blank && (i_pos.x >= 0) && (i_pos.y >= 0)
                       && (i_pos.x < scr_w) && (i_pos.y < scr_h);

    // x below 640 and y below 480 whenever the index is used
    assign row_w = 19'(scr_w[9:0]);
    assign index = 19'(i_pos.y[8:0]) * row_w + 19'(i_pos.x[9:0]);

    assign dbl = (i_cfg.display_mode == MODE_DBL8) || (i_cfg.display_mode == MODE_DBL16);

    always_comb begin
        if (i_cfg.display_mode == MODE_DBL16) begin
            colour = {i_cfg.colour_red[7:3] & MASK_565_RB[7:3],
                      i_cfg.colour_green[7:2] & MASK_565_G[7:2],
                      i_cfg.colour_blue[7:3]};
        end else begin
            colour = {8'h00,
                      i_cfg.colour_red[7:5] & MASK_332_RG[7:5],
                      i_cfg.colour_green[7:5] & MASK_332_RG[7:5],
                      i_cfg.colour_blue[7:6]};
        end
    end

    assign o_item.write_valid   = on_screen;
    assign o_item.pos_x         = i_pos.x;
    assign o_item.pos_y         = i_pos.y;
    assign o_item.buffer_select = on_screen && dbl && i_cfg.draw_buffer;
    assign o_item.pixel_index   = on_screen ? index : '0;
    assign o_item.pixel_value   = on_screen ? colour : '0;
    assign o_item.shape_done    = i_pos.done;

endmodule

`default_nettype wire

>>> src/line_rect_raster_engine.sv
// top level of the line and rectangle raster engine
`timescale 1ns / 1ps
`default_nettype none
`include "line_rect_raster_engine_defines.svh"

// Takes one command per clock (pixel, line start, rectangle start, step) and
// returns exactly one framebuffer write descriptor per command. Commands land
// in an input register, then the shape walker and pixel formatter compute the
// result into the output register while the walker's position registers
// advance. Throughput is one item per clock while i_out_stall is low; the
// limit is the per-item update of the line error term and rectangle position.
// i_in_valid/o_in_stall and o_out_valid/i_out_stall move one item per transfer.
// Configuration writes through i_cfg_we take effect on the next item processed.

module line_rect_raster_engine #(
    parameter int COORD_BITS = lrre_pkg::COORD_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lrre_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output lrre_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [7:0]          i_cfg_data
);
    import lrre_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;

    logic      out_free;
    logic      fire;
    logic      in_take;
    t_pos      pos;
    t_out_item fmt_item;
    logic      out_zero;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    lrre_shape_core #(
        .COORD_BITS(COORD_BITS)
    ) u_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_pos   (pos)
    );

    lrre_pixel_fmt u_fmt (
        .i_cfg  (r_cfg),
        .i_pos  (pos),
        .o_item (fmt_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= fmt_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.display_mode <= MODE_RESET;
            r_cfg.draw_buffer  <= 1'b0;
            r_cfg.colour_red   <= 8'hFF;
            r_cfg.colour_green <= 8'hFF;
            r_cfg.colour_blue  <= 8'hFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DISPLAY_MODE: r_cfg.display_mode <= i_cfg_data[2:0];
                CFG_DRAW_BUFFER:  r_cfg.draw_buffer  <= i_cfg_data[0];
                CFG_COLOUR_RED:   r_cfg.colour_red   <= i_cfg_data;
                CFG_COLOUR_GREEN: r_cfg.colour_green <= i_cfg_data;
                CFG_COLOUR_BLUE:  r_cfg.colour_blue  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_zero = (o_out_item.pixel_index == '0) && (o_out_item.pixel_value == '0)
                      && !o_out_item.buffer_select;

    `LRRE_ASSERT_IMP(a_stall_needs_full_out, o_in_stall, r_out_valid && r_in_valid)
    `LRRE_ASSERT_NXT(a_fire_fills_out, fire, o_out_valid)
    `LRRE_ASSERT_NXT(a_out_drains, o_out_valid && !i_out_stall && !r_in_valid, !o_out_valid)
    `LRRE_ASSERT_IMP(a_clipped_is_zero, o_out_valid && !o_out_item.write_valid, out_zero)

endmodule

`default_nettype wire
